### rtl/crcfp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfp_pkg
// Shared types, codes and the CRC-32 byte step for the frame parser.
// ----------------------------------------------------------------------------
package crcfp_pkg;

   localparam int MAX_PAYLOAD_DEF = 48;   // default payload store depth
   localparam int LEN_W           = 6;    // payload length / position width
   localparam int CNT_W           = 7;    // frame byte counter width
   localparam int HDR_BYTES       = 14;   // marker .. timestamp
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;

   localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
   localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

   // request codes
   localparam logic [1:0] FN_BYTE  = 2'd0;
   localparam logic [1:0] FN_TAKE  = 2'd1;
   localparam logic [1:0] FN_CLEAR = 2'd2;

   // response status codes
   localparam logic [3:0] ST_NEED_MORE   = 4'd0;
   localparam logic [3:0] ST_PENDING     = 4'd1;
   localparam logic [3:0] ST_OVERSIZED   = 4'd2;
   localparam logic [3:0] ST_BAD_VERSION = 4'd3;
   localparam logic [3:0] ST_CRC_BAD     = 4'd4;
   localparam logic [3:0] ST_BAD_TYPE    = 4'd5;
   localparam logic [3:0] ST_READY       = 4'd6;
   localparam logic [3:0] ST_PAYLOAD     = 4'd7;
   localparam logic [3:0] ST_TAKEN       = 4'd8;
   localparam logic [3:0] ST_NONE        = 4'd9;
   localparam logic [3:0] ST_RESET       = 4'd10;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERSION  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_LO  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_HI  = 3'd4;

   typedef struct packed {
      logic [15:0]      magic_word;
      logic [7:0]       protocol_version;
      logic [LEN_W-1:0] payload_limit;
      logic [7:0]       type_lowest;
      logic [7:0]       type_highest;
   } cfg_type;

   typedef struct packed {
      logic [3:0]       status;
      logic [7:0]       msg_type;
      logic [LEN_W-1:0] payload_length;
      logic [31:0]      sequence_number;
      logic [31:0]      capture_time;
      logic [7:0]       payload_value;
      logic [LEN_W-1:0] payload_position;
      logic             last;
   } result_type;

   // parser to readout sequencer
   typedef struct packed {
      logic             ro_start;
      logic [LEN_W-1:0] ro_len;
      logic             waiting;
   } parse_ctl_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/crcfp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crcfp_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 48,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### rtl/crcfp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfp_parse
// Byte-level frame parser: marker hunt, header capture, CRC, frame checks.
// ----------------------------------------------------------------------------
module crcfp_parse #(
   parameter int MAX_PAYLOAD = crcfp_pkg::MAX_PAYLOAD_DEF,
   parameter int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_acc,
   input  wire logic [1:0]             func,
   input  wire logic [7:0]             data_byte,
   input  wire crcfp_pkg::cfg_type     cfg,
   output crcfp_pkg::result_type       res,
   output crcfp_pkg::parse_ctl_type    ctl,
   output logic                        wr_en,
   output logic [ADDR_W-1:0]           wr_addr,
   output logic [7:0]                  wr_data
);
   import crcfp_pkg::*;

   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             wait_ff, wait_in;
   logic [31:0]      crc_ff,  crc_in;
   logic [31:0]      rx_ff,   rx_in;
   logic [7:0]       type_ff, type_in;
   logic [15:0]      dlen_ff, dlen_in;
   logic [31:0]      seq_ff,  seq_in;
   logic [31:0]      time_ff, time_in;

   logic [CNT_W-1:0] k, j;
   logic [31:0]      crc_next;
   logic [LEN_W-1:0] limit;
   logic             store;

   assign k        = cnt_ff - CNT_W'(HDR_BYTES);
   assign j        = k - dlen_ff[CNT_W-1:0];
   assign crc_next = crc_byte(crc_ff, data_byte);
   assign limit    = (cfg.payload_limit > LEN_W'(MAX_PAYLOAD)) ?
                     LEN_W'(MAX_PAYLOAD) : cfg.payload_limit;

   always_comb begin
      cnt_in  = cnt_ff;
      wait_in = wait_ff;
      crc_in  = crc_ff;
      rx_in   = rx_ff;
      type_in = type_ff;
      dlen_in = dlen_ff;
      seq_in  = seq_ff;
      time_in = time_ff;
      store   = 1'b0;
      res      = '0;
      res.last = 1'b1;
      res.status = ST_NONE;
      ctl         = '0;
      ctl.waiting = wait_ff;

      unique case (func)
         FN_BYTE: begin
            res.status = ST_NEED_MORE;
            priority if (wait_ff) begin
               res.status = ST_PENDING;
            end else if (cnt_ff == CNT_W'(0)) begin
               if (data_byte == cfg.magic_word[7:0]) cnt_in = CNT_W'(1);
            end else if (cnt_ff == CNT_W'(1)) begin
               // second byte match wins over a repeated first byte
               priority if (data_byte == cfg.magic_word[15:8]) begin
                  cnt_in = CNT_W'(2);
               end else if (data_byte != cfg.magic_word[7:0]) begin
                  cnt_in = CNT_W'(0);
               end else begin
                  cnt_in = CNT_W'(1);
               end
            end else if (cnt_ff == CNT_W'(2)) begin
               if (data_byte != cfg.protocol_version) begin
                  cnt_in     = CNT_W'(0);
                  res.status = ST_BAD_VERSION;
               end else begin
                  cnt_in = cnt_ff + CNT_W'(1);
                  crc_in = crc_byte(CRC_INIT, data_byte);
               end
            end else if (cnt_ff < CNT_W'(HDR_BYTES)) begin
               cnt_in = cnt_ff + CNT_W'(1);
               crc_in = crc_next;
               priority if (cnt_ff == CNT_W'(3)) begin
                  type_in = data_byte;
               end else if (cnt_ff == CNT_W'(4)) begin
                  dlen_in = {dlen_ff[15:8], data_byte};
               end else if (cnt_ff == CNT_W'(5)) begin
                  dlen_in = {data_byte, dlen_ff[7:0]};
               end else if (cnt_ff < CNT_W'(10)) begin
                  seq_in = {data_byte, seq_ff[31:8]};
               end else begin
                  time_in = {data_byte, time_ff[31:8]};
               end
               // length check once the header is in
               if (cnt_ff == CNT_W'(HDR_BYTES - 1) && dlen_ff > {10'd0, limit}) begin
                  cnt_in     = CNT_W'(0);
                  res.status = ST_OVERSIZED;
               end
            end else if ({9'd0, k} < dlen_ff) begin
               cnt_in = cnt_ff + CNT_W'(1);
               crc_in = crc_next;
               store  = 1'b1;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
               rx_in  = {data_byte, rx_ff[31:8]};
               if (j == CNT_W'(3)) begin
                  priority if (rx_in != ~crc_ff) begin
                     cnt_in     = CNT_W'(0);
                     res.status = ST_CRC_BAD;
                  end else if (type_ff < cfg.type_lowest || type_ff > cfg.type_highest) begin
                     cnt_in     = CNT_W'(0);
                     res.status = ST_BAD_TYPE;
                  end else begin
                     wait_in            = 1'b1;
                     res.status         = ST_READY;
                     res.msg_type       = type_ff;
                     res.payload_length = dlen_ff[LEN_W-1:0];
                     res.sequence_number = seq_ff;
                     res.capture_time   = time_ff;
                  end
               end
            end
         end
         FN_TAKE: begin
            if (wait_ff) begin
               res.status          = ST_TAKEN;
               res.msg_type        = type_ff;
               res.payload_length  = dlen_ff[LEN_W-1:0];
               res.sequence_number = seq_ff;
               res.capture_time    = time_ff;
               res.last            = (dlen_ff[LEN_W-1:0] == '0);
               ctl.ro_start        = (dlen_ff[LEN_W-1:0] != '0);
               ctl.ro_len          = dlen_ff[LEN_W-1:0];
               wait_in             = 1'b0;
               cnt_in              = CNT_W'(0);
            end
         end
         FN_CLEAR: begin
            res.status = ST_RESET;
            wait_in    = 1'b0;
            cnt_in     = CNT_W'(0);
         end
         default: begin
            res.status = ST_NONE;
         end
      endcase
   end

   assign wr_en   = req_acc && store;
   assign wr_addr = k[ADDR_W-1:0];
   assign wr_data = data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         wait_ff <= 1'b0;
      end else if (req_acc) begin
         cnt_ff  <= cnt_in;
         wait_ff <= wait_in;
      end
   end

   // header fields are fully rewritten before use; no reset needed
   always_ff @(posedge clock) begin
      if (req_acc) begin
         crc_ff  <= crc_in;
         rx_ff   <= rx_in;
         type_ff <= type_in;
         dlen_ff <= dlen_in;
         seq_ff  <= seq_in;
         time_ff <= time_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(HDR_BYTES + MAX_PAYLOAD + 4))
      else $error("frame byte counter out of range");

   a_wait_cnt: assert property (@(posedge clock) disable iff (reset)
      wait_ff |-> (cnt_ff == CNT_W'(HDR_BYTES + 4) + dlen_ff[CNT_W-1:0]))
      else $error("held frame with inconsistent byte count");

   a_store_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ({9'd0, k} < dlen_ff && k < CNT_W'(MAX_PAYLOAD)))
      else $error("payload write outside declared length");

endmodule
`default_nettype wire

### rtl/crcfp_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crcfp_outq
// Two-entry response queue; decouples the parser from response stalls.
// ----------------------------------------------------------------------------
module crcfp_outq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire crcfp_pkg::result_type push_data,
   output logic                       full,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output crcfp_pkg::result_type      rsp_data
);
   import crcfp_pkg::*;

   result_type  ent_ff [2];
   logic        head_ff, head_in;
   logic [1:0]  cnt_ff,  cnt_in;
   logic        pop;
   logic        slot;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign full      = (cnt_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = ent_ff[head_ff];
   assign slot      = head_ff ^ cnt_ff[0];

   always_comb begin
      head_in = head_ff ^ pop;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[slot] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("response queue overflow");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("response queue count corrupt");

   a_hold_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(head_ff))
      else $error("queue head moved under stall");

endmodule
`default_nettype wire

### rtl/crc_frame_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// crc_frame_parser
// Length-prefixed frame receiver with CRC-32 trailer; payload held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | content
//  --------+-----+----------------------+-----------------------------------
//  req_    | in  | req_valid/req_stall  | func, data_byte
//  rsp_    | out | rsp_valid/rsp_stall  | status, header fields, payload byte
//  csr_    | in  | csr_valid/csr_ready  | register index, write data
//
//  A received byte, a clear or an empty take is one request, taken back to
//  back while the response queue has room, one response each.
//  A take with a held frame gives 1 + N responses (N payload bytes) and
//  holds req_stall while the payload streams; the payload RAM read port paces it.
//  The two-entry response queue keeps requests flowing while a response waits.
//  Synchronous reset clears the parser and queue; no RAM clearing pass.
//  csr_ready is always high.
// ----------------------------------------------------------------------------
module crc_frame_parser #(
   parameter int MAX_PAYLOAD = crcfp_pkg::MAX_PAYLOAD_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [1:0]                       req_func,
   input  wire logic [7:0]                       req_data_byte,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [3:0]                            rsp_status,
   output logic [7:0]                            rsp_msg_type,
   output logic [crcfp_pkg::LEN_W-1:0]           rsp_payload_length,
   output logic [31:0]                           rsp_sequence_number,
   output logic [31:0]                           rsp_capture_time,
   output logic [7:0]                            rsp_payload_value,
   output logic [crcfp_pkg::LEN_W-1:0]           rsp_payload_position,
   output logic                                  rsp_last,

   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [crcfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [crcfp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import crcfp_pkg::*;

   localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   // configuration registers
   cfg_type cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_word       <= 16'd0;
         cfg_ff.protocol_version <= 8'd1;
         cfg_ff.payload_limit    <= LEN_W'(48);
         cfg_ff.type_lowest      <= 8'd0;
         cfg_ff.type_highest     <= 8'd7;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAGIC:   cfg_ff.magic_word       <= csr_wdata;
            CSR_VERSION: cfg_ff.protocol_version <= csr_wdata[7:0];
            CSR_LIMIT:   cfg_ff.payload_limit    <= csr_wdata[LEN_W-1:0];
            CSR_TYPE_LO: cfg_ff.type_lowest      <= csr_wdata[7:0];
            CSR_TYPE_HI: cfg_ff.type_highest     <= csr_wdata[7:0];
            default: ;   // unmapped index: write dropped
         endcase
      end
   end

   // request path
   logic           req_acc;
   logic           q_full;
   result_type     parse_res;
   parse_ctl_type  parse_ctl;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;

   // readout sequencer: streams the held payload out of the RAM
   logic             rd_busy_ff, rd_busy_in;
   logic             rd_vld_ff,  rd_vld_in;
   logic [LEN_W-1:0] rd_len_ff,  rd_len_in;
   logic [LEN_W-1:0] rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0] rd_pos_ff,  rd_pos_in;
   logic             ro_push, ro_issue, ro_last;
   logic [7:0]       rd_data;
   result_type       ro_res;

   logic       q_push;
   result_type q_data, rsp_data;

   // stall requests while the payload of a take is still streaming or the queue is full
   assign req_stall = rd_busy_ff || q_full;
   assign req_acc   = req_valid && !req_stall;

   crcfp_parse #(
      .MAX_PAYLOAD (MAX_PAYLOAD),
      .ADDR_W      (ADDR_W)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_acc   (req_acc),
      .func      (req_func),
      .data_byte (req_data_byte),
      .cfg       (cfg_ff),
      .res       (parse_res),
      .ctl       (parse_ctl),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   crcfp_ram #(
      .WIDTH  (8),
      .DEPTH  (MAX_PAYLOAD),
      .ADDR_W (ADDR_W)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (ro_issue),
      .rd_addr (rd_addr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // RAM data is pushed once the queue has room; a new read is issued only
   // when the previous data leaves, so the RAM output register holds otherwise
   assign ro_push  = rd_vld_ff && !q_full;
   assign ro_issue = rd_busy_ff && (rd_addr_ff != rd_len_ff) && (!rd_vld_ff || ro_push);
   assign ro_last  = (rd_pos_ff + LEN_W'(1)) == rd_len_ff;

   always_comb begin
      ro_res                  = '0;
      ro_res.status           = ST_PAYLOAD;
      ro_res.payload_value    = rd_data;
      ro_res.payload_position = rd_pos_ff;
      ro_res.last             = ro_last;
   end

   always_comb begin
      rd_busy_in = rd_busy_ff;
      rd_len_in  = rd_len_ff;
      rd_addr_in = rd_addr_ff;
      rd_pos_in  = rd_pos_ff;
      rd_vld_in  = rd_vld_ff;
      if (ro_issue) begin
         rd_addr_in = rd_addr_ff + LEN_W'(1);
         rd_pos_in  = rd_addr_ff;
         rd_vld_in  = 1'b1;
      end else if (ro_push) begin
         rd_vld_in  = 1'b0;
      end
      priority if (req_acc && parse_ctl.ro_start) begin
         rd_busy_in = 1'b1;
         rd_len_in  = parse_ctl.ro_len;
         rd_addr_in = '0;
      end else if (ro_push && ro_last) begin
         rd_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_busy_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else begin
         rd_busy_ff <= rd_busy_in;
         rd_vld_ff  <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_len_ff  <= rd_len_in;
      rd_addr_ff <= rd_addr_in;
      rd_pos_ff  <= rd_pos_in;
   end

   // response queue; the two sources never push in the same cycle
   assign q_push = req_acc || ro_push;
   assign q_data = ro_push ? ro_res : parse_res;

   crcfp_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_status           = rsp_data.status;
   assign rsp_msg_type         = rsp_data.msg_type;
   assign rsp_payload_length   = rsp_data.payload_length;
   assign rsp_sequence_number  = rsp_data.sequence_number;
   assign rsp_capture_time     = rsp_data.capture_time;
   assign rsp_payload_value    = rsp_data.payload_value;
   assign rsp_payload_position = rsp_data.payload_position;
   assign rsp_last             = rsp_data.last;

   a_busy_no_frame: assert property (@(posedge clock) disable iff (reset)
      rd_busy_ff |-> !parse_ctl.waiting)
      else $error("readout running while a frame is still held");

   a_vld_in_busy: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> rd_busy_ff)
      else $error("payload read data outside a readout");

   a_addr_bound: assert property (@(posedge clock) disable iff (reset)
      rd_busy_ff |-> (rd_addr_ff <= rd_len_ff))
      else $error("readout address past payload length");

   a_single_source: assert property (@(posedge clock) disable iff (reset)
      !(req_acc && ro_push))
      else $error("request and readout push collide");

endmodule
`default_nettype wire

### tb/sv/crc_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_frame_parser_tb
// Self-checking bench for the CRC-32 frame parser. Byte, take, clear and
// spare requests are queued by the stimulus process and fed by a clocked
// driver with random gaps. A clocked monitor predicts every response from
// an independent model of the parser and compares all response fields in
// order. Five register settings are visited, extremes included.
// ----------------------------------------------------------------------------
module crc_frame_parser_tb;
   import crcfp_pkg::*;

   // func value with no meaning to the parser; answered with "none"
   localparam logic [1:0] FN_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] data;
   } request_type;

   // how a generated frame is spoilt, if at all
   typedef enum {FLAW_NONE, FLAW_VERSION, FLAW_CRC, FLAW_CUT, FLAW_OVERSIZE} flaw_type;

   // ------------------------------------------------------------------------
   // DUT signals; every input known from time zero
   // ------------------------------------------------------------------------
   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic [1:0]            req_func      = FN_BYTE;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   logic [3:0]            rsp_status;
   logic [7:0]            rsp_msg_type;
   logic [LEN_W-1:0]      rsp_payload_length;
   logic [31:0]           rsp_sequence_number;
   logic [31:0]           rsp_capture_time;
   logic [7:0]            rsp_payload_value;
   logic [LEN_W-1:0]      rsp_payload_position;
   logic                  rsp_last;
   logic                  csr_valid     = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index     = CSR_MAGIC;
   logic [CSR_DATA_W-1:0] csr_wdata     = '0;

   crc_frame_parser dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_func             (req_func),
      .req_data_byte        (req_data_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_msg_type         (rsp_msg_type),
      .rsp_payload_length   (rsp_payload_length),
      .rsp_sequence_number  (rsp_sequence_number),
      .rsp_capture_time     (rsp_capture_time),
      .rsp_payload_value    (rsp_payload_value),
      .rsp_payload_position (rsp_payload_position),
      .rsp_last             (rsp_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   request_type   request_backlog [$];   // requests not yet presented
   result_type    awaited_results [$];   // predicted responses, oldest first
   int            queued_count = 0;
   int            fault_count  = 0;
   cfg_type       stim_cfg;              // settings the stimulus builds frames for

   // handshake flags, set at the rising edge, read by the driver at the falling one
   bit            req_went = 1'b0;
   bit            rsp_went = 1'b0;
   int            req_gap  = 0;
   int            stall_gap = 0;
   bit            req_quiet = 1'b0;      // a spell with no gaps on the request side
   bit            rsp_quiet = 1'b0;      // a spell with no stalls on the response side
   request_type   launch;

   // ------------------------------------------------------------------------
   // Parser model: shadow registers plus frame state
   // ------------------------------------------------------------------------
   cfg_type       live_cfg;
   logic [6:0]    hunt_pos;              // bytes of the current frame so far
   bit            frame_held;
   logic [31:0]   crc_acc;
   logic [31:0]   trailer_word;
   logic [7:0]    hdr_type;
   logic [15:0]   hdr_len;
   logic [31:0]   hdr_seq;
   logic [31:0]   hdr_time;
   logic [7:0]    payload_mem [MAX_PAYLOAD_DEF];

   // reflected CRC-32, LSB first, one byte
   function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
      logic [31:0] c;
      int          k;
      c = acc ^ {24'd0, b};
      for (k = 0; k < 8; k++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic void clear_frame();
      hunt_pos     = '0;
      frame_held   = 1'b0;
      crc_acc      = CRC_INIT;
      trailer_word = '0;
      hdr_type     = '0;
      hdr_len      = '0;
      hdr_seq      = '0;
      hdr_time     = '0;
   endfunction

   function automatic void reset_model();
      live_cfg = '{16'h0000, 8'h01, 6'd48, 8'd0, 8'd7};
      clear_frame();
      foreach (payload_mem[i]) payload_mem[i] = 8'h00;
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] wdata);
      case (idx)
         CSR_MAGIC:   live_cfg.magic_word       = wdata;
         CSR_VERSION: live_cfg.protocol_version = wdata[7:0];
         CSR_LIMIT:   live_cfg.payload_limit    = wdata[LEN_W-1:0];
         CSR_TYPE_LO: live_cfg.type_lowest      = wdata[7:0];
         CSR_TYPE_HI: live_cfg.type_highest     = wdata[7:0];
         default: ;
      endcase
   endfunction

   function automatic result_type make_result(input logic [3:0] st, input bit with_hdr,
                                              input logic [7:0] val,
                                              input logic [LEN_W-1:0] pos, input bit fin);
      result_type r;
      r.status           = st;
      r.msg_type         = with_hdr ? hdr_type : 8'h00;
      r.payload_length   = with_hdr ? hdr_len[LEN_W-1:0] : '0;
      r.sequence_number  = with_hdr ? hdr_seq : 32'h0;
      r.capture_time     = with_hdr ? hdr_time : 32'h0;
      r.payload_value    = val;
      r.payload_position = pos;
      r.last             = fin;
      return r;
   endfunction

   // one received byte through the frame state machine; returns the status
   function automatic logic [3:0] parse_byte(input logic [7:0] b);
      int p;
      int eff;
      if (frame_held)
         return ST_PENDING;
      // marker hunt; second-byte match wins when both marker bytes are equal,
      // and a repeated first byte keeps one byte matched
      if (hunt_pos == 0) begin
         if (b == live_cfg.magic_word[7:0]) hunt_pos = 7'd1;
         return ST_NEED_MORE;
      end
      if (hunt_pos == 1) begin
         if (b == live_cfg.magic_word[15:8]) hunt_pos = 7'd2;
         else if (b != live_cfg.magic_word[7:0]) hunt_pos = 7'd0;
         return ST_NEED_MORE;
      end
      p = hunt_pos;
      hunt_pos = hunt_pos + 7'd1;
      if (p == 2) begin
         if (b != live_cfg.protocol_version) begin
            clear_frame();
            return ST_BAD_VERSION;
         end
         crc_acc = crc32_step(CRC_INIT, b);
         return ST_NEED_MORE;
      end
      if (p < HDR_BYTES) begin
         crc_acc = crc32_step(crc_acc, b);
         if (p == 3)       hdr_type      = b;
         else if (p == 4)  hdr_len[7:0]  = b;
         else if (p == 5)  hdr_len[15:8] = b;
         else if (p < 10)  hdr_seq       = {b, hdr_seq[31:8]};
         else              hdr_time      = {b, hdr_time[31:8]};
         if (p == HDR_BYTES - 1) begin
            // limit register saturates at the store depth
            eff = (live_cfg.payload_limit > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF
                                                              : live_cfg.payload_limit;
            if (hdr_len > eff) begin
               clear_frame();
               return ST_OVERSIZED;
            end
         end
         return ST_NEED_MORE;
      end
      if (p < HDR_BYTES + hdr_len) begin
         payload_mem[p - HDR_BYTES] = b;
         crc_acc = crc32_step(crc_acc, b);
         return ST_NEED_MORE;
      end
      trailer_word = {b, trailer_word[31:8]};
      if (p - HDR_BYTES - hdr_len < 3)
         return ST_NEED_MORE;
      // CRC is judged before the type
      if (trailer_word != ~crc_acc) begin
         clear_frame();
         return ST_CRC_BAD;
      end
      if (hdr_type < live_cfg.type_lowest || hdr_type > live_cfg.type_highest) begin
         clear_frame();
         return ST_BAD_TYPE;
      end
      frame_held = 1'b1;
      return ST_READY;
   endfunction

   // all responses one accepted request gives rise to
   function automatic void predict_parser(input logic [1:0] func, input logic [7:0] b);
      logic [3:0] st;
      int         len;
      int         i;
      if (func == FN_BYTE) begin
         st = parse_byte(b);
         awaited_results.push_back(make_result(st, st == ST_READY, 8'h00, '0, 1'b1));
      end else if (func == FN_CLEAR) begin
         clear_frame();
         awaited_results.push_back(make_result(ST_RESET, 1'b0, 8'h00, '0, 1'b1));
      end else if (func == FN_SPARE || !frame_held) begin
         awaited_results.push_back(make_result(ST_NONE, 1'b0, 8'h00, '0, 1'b1));
      end else begin
         // header first, then the payload run
         len = (hdr_len > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : hdr_len;
         awaited_results.push_back(make_result(ST_TAKEN, 1'b1, 8'h00, '0, len == 0));
         for (i = 0; i < len; i++)
            awaited_results.push_back(make_result(ST_PAYLOAD, 1'b0, payload_mem[i],
                                                  LEN_W'(i), i + 1 == len));
         clear_frame();
      end
   endfunction

   task automatic check_response();
      result_type seen;
      result_type want;
      seen = '{rsp_status, rsp_msg_type, rsp_payload_length, rsp_sequence_number,
               rsp_capture_time, rsp_payload_value, rsp_payload_position, rsp_last};
      if (awaited_results.size() == 0) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: response with none outstanding, status %0d", $realtime,
                     seen.status);
      end else begin
         want = awaited_results.pop_front();
         if (seen !== want) begin
            fault_count++;
            if (fault_count <= 10) begin
               $display("%0t: mismatch exp st=%0d ty=%h len=%0d seq=%h tim=%h val=%h pos=%0d l=%b",
                        $realtime, want.status, want.msg_type, want.payload_length,
                        want.sequence_number, want.capture_time, want.payload_value,
                        want.payload_position, want.last);
               $display("%0t:          got st=%0d ty=%h len=%0d seq=%h tim=%h val=%h pos=%0d l=%b",
                        $realtime, seen.status, seen.msg_type, seen.payload_length,
                        seen.sequence_number, seen.capture_time, seen.payload_value,
                        seen.payload_position, seen.last);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: rising edge. Register writes land first, then the accepted
   // request is predicted, then the response is checked. A response comes
   // out of a registered queue, never in the same cycle as its request.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         reset_model();
         awaited_results.delete();
         req_went = 1'b0;
         rsp_went = 1'b0;
      end else begin
         if (csr_valid && csr_ready)
            apply_register(csr_index, csr_wdata);
         req_went = req_valid && !req_stall;
         if (req_went)
            predict_parser(req_func, req_data_byte);
         rsp_went = rsp_valid && !rsp_stall;
         if (rsp_went)
            check_response();
      end
   end

   // ------------------------------------------------------------------------
   // Driver: falling edge. A request stays put until accepted; after each
   // one a random gap is drawn. The response side draws a random stall
   // after each response it takes. Quiet spells switch the random gaps
   // off for a while on either side.
   // ------------------------------------------------------------------------
   function automatic int pick_wait(input bit quiet);
      return quiet ? 0 : int'($urandom_range(10, 0));
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
         req_gap   = 0;
         stall_gap = 0;
      end else begin
         if (req_valid && !req_went) begin
            // held request: nothing moves
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (request_backlog.size() != 0) begin
            launch = request_backlog.pop_front();
            req_func      <= launch.func;
            req_data_byte <= launch.data;
            req_valid     <= 1'b1;
            if ($urandom_range(15, 0) == 0) req_quiet = ~req_quiet;
            req_gap = pick_wait(req_quiet);
         end else begin
            req_valid <= 1'b0;
         end

         if (rsp_went) begin
            if ($urandom_range(15, 0) == 0) rsp_quiet = ~rsp_quiet;
            stall_gap = pick_wait(rsp_quiet);
         end
         if (stall_gap > 0) begin
            stall_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_request(input logic [1:0] func, input logic [7:0] b);
      request_backlog.push_back('{func, b});
      queued_count++;
   endtask

   // block must be idle before a register write: all requests in, all answered
   task automatic wait_drained();
      while (request_backlog.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wdata;
      do @(posedge clock); while (!csr_ready);
   endtask

   // unused upper data bits carry noise; the block must drop them
   task automatic program_settings(input cfg_type s);
      write_register(CSR_MAGIC,   s.magic_word);
      write_register(CSR_VERSION, {8'($urandom), s.protocol_version});
      write_register(CSR_LIMIT,   {10'($urandom), s.payload_limit});
      write_register(CSR_TYPE_LO, {8'($urandom), s.type_lowest});
      write_register(CSR_TYPE_HI, {8'($urandom), s.type_highest});
      @(negedge clock);
      csr_valid <= 1'b0;
      stim_cfg = s;
   endtask

   function automatic logic [7:0] good_type();
      if (stim_cfg.type_lowest <= stim_cfg.type_highest)
         return 8'($urandom_range(stim_cfg.type_highest, stim_cfg.type_lowest));
      return 8'($urandom);   // empty range: nothing is good
   endfunction

   function automatic logic [7:0] stray_type();
      if (stim_cfg.type_lowest > 0 &&
          (stim_cfg.type_highest == 8'hFF || $urandom_range(1, 0) == 1))
         return 8'($urandom_range(stim_cfg.type_lowest - 1, 0));
      if (stim_cfg.type_highest < 8'hFF)
         return 8'($urandom_range(255, stim_cfg.type_highest + 1));
      return 8'($urandom);
   endfunction

   // marker, version, type, length, sequence, time, payload, CRC trailer
   task automatic build_frame(input logic [7:0] msg, input logic [15:0] len_field,
                              input flaw_type flaw);
      logic [7:0]  fb [$];
      logic [31:0] acc;
      logic [7:0]  ver;
      int          cut;
      int          i;
      ver = stim_cfg.protocol_version;
      if (flaw == FLAW_VERSION) ver = ver ^ 8'($urandom_range(255, 1));
      fb.push_back(stim_cfg.magic_word[7:0]);
      fb.push_back(stim_cfg.magic_word[15:8]);
      fb.push_back(ver);
      fb.push_back(msg);
      fb.push_back(len_field[7:0]);
      fb.push_back(len_field[15:8]);
      repeat (8) fb.push_back(8'($urandom));
      // an oversized header ends the frame; no body is sent
      if (flaw != FLAW_OVERSIZE) begin
         repeat (len_field) fb.push_back(8'($urandom));
         acc = CRC_INIT;
         for (i = 2; i < fb.size(); i++) acc = crc32_step(acc, fb[i]);
         acc = ~acc;
         if (flaw == FLAW_CRC) acc = acc ^ (32'd1 << $urandom_range(31, 0));
         for (i = 0; i < 4; i++) fb.push_back(acc[8*i +: 8]);
      end
      cut = fb.size();
      if (flaw == FLAW_CUT) cut = $urandom_range(fb.size() - 1, 1);
      for (i = 0; i < cut; i++) queue_request(FN_BYTE, fb[i]);
      if (flaw == FLAW_CUT) queue_request(FN_CLEAR, 8'($urandom));
   endtask

   // mostly well-formed frames with short payloads, the rest spoilt frames
   // and loose requests
   task automatic queue_random_traffic(input int amount);
      int start;
      int r;
      int eff;
      int len;
      start = queued_count;
      while (queued_count - start < amount) begin
         eff = (stim_cfg.payload_limit > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF
                                                          : stim_cfg.payload_limit;
         if ($urandom_range(9, 0) == 0) len = $urandom_range(eff, 0);
         else                           len = $urandom_range((eff < 6) ? eff : 6, 0);
         r = $urandom_range(99, 0);
         if (r < 55) begin
            build_frame(good_type(), 16'(len), FLAW_NONE);
            if ($urandom_range(4, 0) == 0) queue_request(FN_BYTE, 8'($urandom));
            if ($urandom_range(9, 0) != 0) queue_request(FN_TAKE, 8'($urandom));
         end else if (r < 62) begin
            build_frame(good_type(), 16'(len), FLAW_CRC);
         end else if (r < 68) begin
            build_frame(stray_type(), 16'(len), FLAW_NONE);
         end else if (r < 73) begin
            build_frame(good_type(), 16'(len), FLAW_VERSION);
         end else if (r < 78) begin
            build_frame(good_type(),
                        ($urandom_range(1, 0) == 1) ? 16'(eff + 1)
                                                    : 16'($urandom_range(65535, eff + 1)),
                        FLAW_OVERSIZE);
         end else if (r < 83) begin
            build_frame(good_type(), 16'(len), FLAW_CUT);
         end else if (r < 90) begin
            repeat ($urandom_range(5, 1)) queue_request(FN_BYTE, 8'($urandom));
         end else if (r < 95) begin
            queue_request(FN_TAKE, 8'($urandom));
         end else begin
            queue_request(($urandom_range(1, 0) == 1) ? FN_CLEAR : FN_SPARE, 8'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   cfg_type phase_cfg [4];
   int      ph;

   initial begin
      stim_cfg     = '{16'h0000, 8'h01, 6'd48, 8'd0, 8'd7};
      // limit above the store depth saturates; wide type window
      phase_cfg[0] = '{16'hA55A, 8'h02, 6'd63, 8'd1,   8'd200};
      // all-ones marker and version, zero-length payloads only, full type range
      phase_cfg[1] = '{16'hFFFF, 8'hFF, 6'd0,  8'd0,   8'd255};
      // equal marker bytes, version zero, inverted type window: no type valid
      phase_cfg[2] = '{16'h3C3C, 8'h00, 6'd9,  8'd12,  8'd3};
      // single valid type at the top
      phase_cfg[3] = '{16'h00FF, 8'h80, 6'd48, 8'd255, 8'd255};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings: marker 0x0000, version 1, types 0..7
      queue_request(FN_TAKE,  8'h00);   // nothing held
      queue_request(FN_SPARE, 8'hFF);   // unused code
      queue_request(FN_BYTE,  8'hFF);   // noise while hunting
      queue_request(FN_BYTE,  8'h00);   // first marker byte
      queue_request(FN_BYTE,  8'h00);   // equal bytes: counts as the second
      queue_request(FN_BYTE,  8'h00);   // version 0, wrong
      queue_request(FN_BYTE,  8'h00);   // hunt restarts
      queue_request(FN_CLEAR, 8'h00);   // parser clear mid-hunt
      build_frame(8'd7, 16'd1, FLAW_NONE);
      queue_request(FN_BYTE,  8'hFF);   // ignored while a frame is held
      queue_request(FN_TAKE,  8'hFF);

      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         program_settings(phase_cfg[ph]);
         if (ph == 0) begin
            // largest payload, and one byte past the saturated limit
            build_frame(good_type(), 16'd48, FLAW_NONE);
            queue_request(FN_TAKE, 8'h00);
            build_frame(good_type(), 16'd49, FLAW_OVERSIZE);
         end else begin
            queue_random_traffic(8);
         end
      end

      wait_drained();
      repeat (60) @(posedge clock);
      if (fault_count == 0 && awaited_results.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #(64'd40_000_000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
